// ===== src/tlg_pkg.sv =====
// Shared types, codes and constants for the toroidal Life grid with trails.
package tlg_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;
  localparam logic [31:0] ZERO_SEED_SUB = 32'h9e37_79b9;

  localparam logic [2:0] OP_SET   = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_STEP  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_SEED  = 3'd4;

  localparam logic [2:0] REG_COLS   = 3'd0;
  localparam logic [2:0] REG_ROWS   = 3'd1;
  localparam logic [2:0] REG_TRAIL  = 3'd2;
  localparam logic [2:0] REG_ENABLE = 3'd3;
  localparam logic [2:0] REG_THRESH = 3'd4;

  typedef enum logic [2:0] {
    CMD_SET,
    CMD_READ,
    CMD_STEP,
    CMD_CLEAR,
    CMD_SEED,
    CMD_NONE
  } cmd_kind_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_LIFE,
    ST_COMMIT,
    ST_SEED,
    ST_CLEAR,
    ST_COUNT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic        alive_in;
    logic [31:0] rng_seed;
  } in_word_t;

  typedef struct packed {
    logic        cell_alive;
    logic [7:0]  cell_trail;
    logic [12:0] live_count;
    logic [31:0] rng_state_out;
    logic        out_of_range;
  } out_word_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic        alive_in;
    logic [31:0] rng_seed;
    logic        in_grid;
  } cmd_t;

endpackage

// ===== src/tlg_fifo.sv =====
// Small register queue used between the front, the engine and the result port.
module tlg_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end
endmodule

// ===== src/tlg_front.sv =====
// Front end: decodes an input word into an engine command and checks its address.
module tlg_front #(
  parameter int CW = 7,
  parameter int RW = 7
) (
  input  tlg_pkg::in_word_t item,
  input  logic [CW-1:0]     ecols,
  input  logic [RW-1:0]     erows,
  output tlg_pkg::cmd_t     cmd
);
  import tlg_pkg::*;

  always_comb begin
    cmd.cell_x   = item.cell_x;
    cmd.cell_y   = item.cell_y;
    cmd.alive_in = item.alive_in;
    cmd.rng_seed = item.rng_seed;
    cmd.in_grid  = (32'(item.cell_x) < 32'(ecols)) && (32'(item.cell_y) < 32'(erows));
    case (item.op)
      OP_SET:   cmd.kind = CMD_SET;
      OP_READ:  cmd.kind = CMD_READ;
      OP_STEP:  cmd.kind = CMD_STEP;
      OP_CLEAR: cmd.kind = CMD_CLEAR;
      OP_SEED:  cmd.kind = CMD_SEED;
      default:  cmd.kind = CMD_NONE;
    endcase
  end
endmodule

// ===== src/tlg_engine.sv =====
// Back end: sequences the grid memories through set, read, step, clear, seed and count.
module tlg_engine #(
  parameter int MAX_COLS = tlg_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tlg_pkg::MAX_ROWS_DEF,
  parameter int CW       = $clog2(MAX_COLS + 1),
  parameter int RW       = $clog2(MAX_ROWS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  tlg_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic [CW-1:0]      ecols,
  input  logic [RW-1:0]      erows,
  input  logic [7:0]         trail_len,
  input  logic               trail_en,
  input  logic [31:0]        threshold,
  input  logic               res_full,
  output logic               res_push,
  output tlg_pkg::out_word_t res,
  output logic               init_busy
);
  import tlg_pkg::*;

  localparam int XW    = $clog2(MAX_COLS);
  localparam int YW    = $clog2(MAX_ROWS);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int LW    = $clog2(MAX_COLS * MAX_ROWS + 1);

  state_t        state;
  state_t        state_next;
  cmd_t          cur;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [3:0]    sub;
  logic [3:0]    nsum;
  logic          center;
  logic [LW-1:0] cnt;
  logic [31:0]   rng;
  logic          r_alive;
  logic [7:0]    r_trail;
  logic [AW-1:0] clr_addr;

  logic [8:0]    mem_cell [DEPTH];
  logic          mem_next [DEPTH];
  logic [8:0]    cell_q;
  logic          next_q;

  logic          cell_we;
  logic [AW-1:0] cell_wa;
  logic [8:0]    cell_wd;
  logic [AW-1:0] cell_ra;
  logic          next_we;
  logic [AW-1:0] next_wa;
  logic          next_wd;

  logic          last_x;
  logic          last_y;
  logic          last_cell;
  logic [XW-1:0] xm;
  logic [XW-1:0] xp;
  logic [YW-1:0] ym;
  logic [YW-1:0] yp;
  logic [XW-1:0] sel_x;
  logic [YW-1:0] sel_y;
  logic [XW-1:0] ax;
  logic [YW-1:0] ay;
  logic [3:0]    nfin;
  logic          life;
  logic [7:0]    fade;
  logic [31:0]   s0;
  logic [31:0]   s1;
  logic [31:0]   s2;
  logic [31:0]   s3;
  logic          seed_alive;

  assign last_x    = (CW'(cx) == ecols - CW'(1));
  assign last_y    = (RW'(cy) == erows - RW'(1));
  assign last_cell = last_x && last_y;
  assign xm        = (cx == '0) ? XW'(ecols - CW'(1)) : cx - XW'(1);
  assign xp        = last_x ? '0 : cx + XW'(1);
  assign ym        = (cy == '0) ? YW'(erows - RW'(1)) : cy - YW'(1);
  assign yp        = last_y ? '0 : cy + YW'(1);
  assign ax        = XW'(cur.cell_x);
  assign ay        = YW'(cur.cell_y);
  assign nfin      = nsum + 4'(cell_q[8]);
  assign life      = center ? (nfin == 4'd2 || nfin == 4'd3) : (nfin == 4'd3);
  assign fade      = (trail_en && cell_q[7:0] != 8'd0) ? cell_q[7:0] - 8'd1 : 8'd0;
  assign s0        = (rng == 32'd0) ? ZERO_SEED_SUB : rng;
  assign s1        = s0 ^ (s0 << 13);
  assign s2        = s1 ^ (s1 >> 17);
  assign s3        = s2 ^ (s2 << 5);
  assign seed_alive = (s3 <= threshold);
  assign init_busy = (state == ST_INIT);

  always_comb begin
    case (sub)
      4'd1:    begin sel_y = ym; sel_x = xm; end
      4'd2:    begin sel_y = ym; sel_x = cx; end
      4'd3:    begin sel_y = ym; sel_x = xp; end
      4'd4:    begin sel_y = cy; sel_x = xm; end
      4'd5:    begin sel_y = cy; sel_x = xp; end
      4'd6:    begin sel_y = yp; sel_x = xm; end
      4'd7:    begin sel_y = yp; sel_x = cx; end
      4'd8:    begin sel_y = yp; sel_x = xp; end
      default: begin sel_y = cy; sel_x = cx; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_SET, CMD_READ: state_next = cmd.in_grid ? ST_ACC_RD : ST_COUNT;
            CMD_STEP:          state_next = ST_LIFE;
            CMD_CLEAR:         state_next = ST_CLEAR;
            CMD_SEED:          state_next = ST_SEED;
            default:           state_next = ST_COUNT;
          endcase
        end
      end
      ST_ACC_RD: state_next = ST_ACC_WR;
      ST_ACC_WR: state_next = ST_COUNT;
      ST_LIFE: begin
        if (sub == 4'd9 && last_cell) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sub == 4'd1 && last_cell) state_next = ST_COUNT;
      end
      ST_SEED: begin
        if (last_cell) state_next = ST_COUNT;
      end
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = ST_COUNT;
      end
      ST_COUNT: begin
        if (sub == 4'd1 && last_cell) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res_full) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    cell_we  = 1'b0;
    cell_wa  = {cy, cx};
    cell_wd  = '0;
    cell_ra  = {cy, cx};
    next_we  = 1'b0;
    next_wa  = {cy, cx};
    next_wd  = life;
    case (state)
      ST_INIT, ST_CLEAR: begin
        cell_we = 1'b1;
        cell_wa = clr_addr;
      end
      ST_IDLE:   cmd_pop = cmd_valid;
      ST_ACC_RD: cell_ra = {ay, ax};
      ST_ACC_WR: begin
        cell_wa = {ay, ax};
        cell_we = (cur.kind == CMD_SET);
        cell_wd = {cur.alive_in, cur.alive_in ? trail_len : cell_q[7:0]};
      end
      ST_LIFE: begin
        cell_ra = {sel_y, sel_x};
        next_we = (sub == 4'd9);
      end
      ST_COMMIT: begin
        cell_we = (sub == 4'd1);
        cell_wd = {next_q, next_q ? trail_len : fade};
      end
      ST_SEED: begin
        cell_we = 1'b1;
        cell_wd = {seed_alive, seed_alive ? trail_len : 8'd0};
      end
      ST_DONE: res_push = !res_full;
      default: cmd_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      mem_cell[cell_wa] <= cell_wd;
    end
    cell_q <= mem_cell[cell_ra];
    if (next_we) begin
      mem_next[next_wa] <= next_wd;
    end
    next_q <= mem_next[{cy, cx}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      clr_addr <= '0;
      cx       <= '0;
      cy       <= '0;
      sub      <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_INIT, ST_CLEAR: clr_addr <= clr_addr + AW'(1);
        ST_IDLE: begin
          if (cmd_valid) begin
            cx  <= '0;
            cy  <= '0;
            sub <= '0;
          end
        end
        ST_LIFE: begin
          if (sub == 4'd9) begin
            sub <= '0;
            if (last_x) begin
              cx <= '0;
              cy <= last_y ? '0 : cy + YW'(1);
            end else begin
              cx <= cx + XW'(1);
            end
          end else begin
            sub <= sub + 4'd1;
          end
        end
        ST_COMMIT, ST_COUNT: begin
          if (sub == 4'd1) begin
            sub <= '0;
            if (last_x) begin
              cx <= '0;
              cy <= last_y ? '0 : cy + YW'(1);
            end else begin
              cx <= cx + XW'(1);
            end
          end else begin
            sub <= 4'd1;
          end
        end
        ST_SEED: begin
          if (last_x) begin
            cx <= '0;
            cy <= last_y ? '0 : cy + YW'(1);
          end else begin
            cx <= cx + XW'(1);
          end
        end
        default: sub <= sub;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur     <= cmd;
        cnt     <= '0;
        rng     <= cmd.rng_seed;
        r_alive <= 1'b0;
        r_trail <= 8'd0;
      end
      ST_ACC_WR: begin
        if (cur.kind == CMD_READ) begin
          r_alive <= cell_q[8];
          r_trail <= cell_q[7:0];
        end
      end
      ST_LIFE: begin
        if (sub == 4'd1) begin
          center <= cell_q[8];
          nsum   <= 4'd0;
        end else if (sub != 4'd0) begin
          nsum <= nfin;
        end
      end
      ST_SEED:  rng <= s3;
      ST_COUNT: begin
        if (sub == 4'd1) cnt <= cnt + LW'(cell_q[8]);
      end
      default: cnt <= cnt;
    endcase
  end

  always_comb begin
    res.cell_alive    = r_alive;
    res.cell_trail    = r_trail;
    res.live_count    = 13'(cnt);
    res.rng_state_out = (cur.kind == CMD_SEED) ? rng : 32'd0;
    res.out_of_range  = (cur.kind == CMD_SET || cur.kind == CMD_READ) && !cur.in_grid;
  end
endmodule

// ===== src/toroidal_life_grid_with_trails.sv =====
// Top level of the toroidal Life grid with trails: registers, queues, front and engine.
// Usage:
// Input words are pushed while full is low; each word is one operation (set cell,
// read cell, step, clear, seed). Exactly one result word comes back for each, in
// order, shown while empty is low and taken with pop. Registers sit on the APB
// port; the user must see that they are written only while the block is idle,
// since the block itself does not enforce it. Every operation ends with a count
// pass over the active area. Set and read access one in-range cell before that pass;
// a step reads each active cell and its neighbors through the single read port,
// then commits the new generation, plus the count; seed passes over the active
// cells and clear over the whole memory, both plus the count.
// After reset a clearing pass of one cell per cycle runs over the whole memory;
// full stays high until it ends.
// Two command words and two result words can wait in the queues; when results are
// not popped, the engine holds its finished word and input fills the queue.
module toroidal_life_grid_with_trails #(
  parameter int MAX_COLS = tlg_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tlg_pkg::MAX_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tlg_pkg::in_word_t  item,
  output logic               full,
  input  logic               pop,
  output tlg_pkg::out_word_t result,
  output logic               empty,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tlg_pkg::*;

  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CMDW = $bits(cmd_t);
  localparam int OUTW = $bits(out_word_t);

  logic [6:0]    grid_cols;
  logic [6:0]    grid_rows;
  logic [7:0]    trail_length;
  logic          trail_enable;
  logic [31:0]   density_threshold;
  logic [CW-1:0] ecols;
  logic [RW-1:0] erows;
  logic [7:0]    etrail;
  logic [2:0]    reg_idx;

  cmd_t          front_cmd;
  cmd_t          eng_cmd;
  logic [CMDW-1:0] cmd_bits;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          init_busy;
  logic          res_push;
  logic          res_full;
  out_word_t     eng_res;
  logic [OUTW-1:0] res_bits;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols         <= 7'd64;
      grid_rows         <= 7'd64;
      trail_length      <= 8'd1;
      trail_enable      <= 1'b0;
      density_threshold <= 32'd0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_COLS:   grid_cols         <= pwdata[6:0];
        REG_ROWS:   grid_rows         <= pwdata[6:0];
        REG_TRAIL:  trail_length      <= pwdata[7:0];
        REG_ENABLE: trail_enable      <= pwdata[0];
        REG_THRESH: density_threshold <= pwdata;
        default:    grid_cols         <= grid_cols;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COLS:   prdata = 32'(grid_cols);
      REG_ROWS:   prdata = 32'(grid_rows);
      REG_TRAIL:  prdata = 32'(trail_length);
      REG_ENABLE: prdata = 32'(trail_enable);
      REG_THRESH: prdata = density_threshold;
      default:    prdata = 32'd0;
    endcase
  end

  assign ecols  = (grid_cols == 7'd0) ? CW'(1) :
                  (32'(grid_cols) > MAX_COLS) ? CW'(MAX_COLS) : CW'(grid_cols);
  assign erows  = (grid_rows == 7'd0) ? RW'(1) :
                  (32'(grid_rows) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(grid_rows);
  assign etrail = (trail_length == 8'd0) ? 8'd1 : trail_length;

  tlg_front #(.CW(CW), .RW(RW)) u_front (
    .item  (item),
    .ecols (ecols),
    .erows (erows),
    .cmd   (front_cmd)
  );

  tlg_fifo #(.W(CMDW), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !init_busy),
    .din   (front_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_bits),
    .empty (cmd_empty)
  );

  assign full    = cmd_full || init_busy;
  assign eng_cmd = cmd_t'(cmd_bits);

  tlg_engine #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (eng_cmd),
    .cmd_pop   (cmd_pop),
    .ecols     (ecols),
    .erows     (erows),
    .trail_len (etrail),
    .trail_en  (trail_enable),
    .threshold (density_threshold),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (eng_res),
    .init_busy (init_busy)
  );

  tlg_fifo #(.W(OUTW), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (eng_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_bits),
    .empty (empty)
  );

  assign result = out_word_t'(res_bits);
endmodule

// ===== src/tlg_checker.sv =====
// Port-level checks for the toroidal Life grid, bound to the top level.
module tlg_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               pop,
  input tlg_pkg::out_word_t result,
  input logic               empty,
  input logic               pready
);
  import tlg_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_full_after_reset: assert property (@(posedge clk) rst |=> full)
    else $error("input taken during the clearing pass");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result word changed");

  a_oor_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.out_of_range) |->
      (!result.cell_alive && result.cell_trail == 8'd0 && result.rng_state_out == 32'd0))
    else $error("out-of-range result carries data");

  a_alive_has_trail: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.cell_alive) |-> (result.cell_trail != 8'd0 && pready))
    else $error("live cell read with zero trail");
endmodule

bind toroidal_life_grid_with_trails tlg_checker u_tlg_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .pop    (pop),
  .result (result),
  .empty  (empty),
  .pready (pready)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the toroidal Life grid with trails, with its own grid predictor.
`timescale 1ns / 1ps

module testbench;
  import tlg_pkg::*;

  localparam int NCOLS = 64;
  localparam int NROWS = 64;
  localparam int NCELLS = NCOLS * NROWS;
  localparam int STALL_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_POP = 80;
  localparam int RAND_PHASES = 7;
  localparam int WORDS_PER_PHASE = 17;

  localparam logic [2:0] OP_BAD5 = 3'd5;
  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  in_word_t item = '0;
  logic full;
  logic pop = 1'b0;
  out_word_t result;
  logic empty;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  toroidal_life_grid_with_trails u_dut (
    .clk(clk), .rst(rst), .push(push), .item(item), .full(full), .pop(pop),
    .result(result), .empty(empty), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted grid state and register copy.
  bit cell_live [NCELLS];
  bit cell_next [NCELLS];
  logic [7:0] cell_fade [NCELLS];
  logic [6:0] cols_reg = 7'd64;
  logic [6:0] rows_reg = 7'd64;
  logic [7:0] fade_len_reg = 8'd1;
  logic fade_en_reg = 1'b0;
  logic [31:0] density_reg = '0;

  out_word_t pending_results[$];
  int errors = 0;
  int pops_done = 0;
  bit calm = 1'b0;

  function automatic int active_cols();
    if (cols_reg == 0) return 1;
    return (cols_reg > NCOLS) ? NCOLS : int'(cols_reg);
  endfunction

  function automatic int active_rows();
    if (rows_reg == 0) return 1;
    return (rows_reg > NROWS) ? NROWS : int'(rows_reg);
  endfunction

  function automatic logic [7:0] live_fade();
    return (fade_len_reg == 0) ? 8'd1 : fade_len_reg;
  endfunction

  function automatic int count_alive();
    int n;
    n = 0;
    for (int y = 0; y < active_rows(); y++)
      for (int x = 0; x < active_cols(); x++)
        n += cell_live[y * NCOLS + x];
    return n;
  endfunction

  function automatic void advance_generation();
    int cw, rh, n, k;
    int ys[3];
    int xs[3];
    cw = active_cols();
    rh = active_rows();
    for (int y = 0; y < rh; y++)
      for (int x = 0; x < cw; x++) begin
        ys = '{(y + rh - 1) % rh, y, (y + 1) % rh};
        xs = '{(x + cw - 1) % cw, x, (x + 1) % cw};
        n = 0;
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            if (!(i == 1 && j == 1)) n += cell_live[ys[i] * NCOLS + xs[j]];
        k = y * NCOLS + x;
        cell_next[k] = cell_live[k] ? (n == 2 || n == 3) : (n == 3);
      end
    for (int y = 0; y < rh; y++)
      for (int x = 0; x < cw; x++) begin
        k = y * NCOLS + x;
        if (cell_next[k]) cell_fade[k] = live_fade();
        else if (fade_en_reg && cell_fade[k] > 0) cell_fade[k] = cell_fade[k] - 8'd1;
        else cell_fade[k] = 8'd0;
        cell_live[k] = cell_next[k];
      end
  endfunction

  function automatic logic [31:0] seed_grid(logic [31:0] s);
    int k;
    for (int y = 0; y < active_rows(); y++)
      for (int x = 0; x < active_cols(); x++) begin
        k = y * NCOLS + x;
        if (s == 0) s = ZERO_SEED_SUB;
        s ^= s << 13;
        s ^= s >> 17;
        s ^= s << 5;
        cell_live[k] = (s <= density_reg);
        cell_fade[k] = cell_live[k] ? live_fade() : 8'd0;
      end
    return s;
  endfunction

  function automatic out_word_t apply_word(in_word_t w);
    out_word_t r;
    bit in_grid;
    int k;
    r = '0;
    in_grid = (w.cell_x < active_cols()) && (w.cell_y < active_rows());
    k = int'(w.cell_y) * NCOLS + int'(w.cell_x);
    case (w.op)
      OP_SET: begin
        if (!in_grid) r.out_of_range = 1'b1;
        else begin
          cell_live[k] = w.alive_in;
          if (w.alive_in) cell_fade[k] = live_fade();
        end
      end
      OP_READ: begin
        if (!in_grid) r.out_of_range = 1'b1;
        else begin
          r.cell_alive = cell_live[k];
          r.cell_trail = cell_fade[k];
        end
      end
      OP_STEP: advance_generation();
      OP_CLEAR: begin
        for (int i = 0; i < NCELLS; i++) begin
          cell_live[i] = 1'b0;
          cell_fade[i] = 8'd0;
        end
      end
      OP_SEED: r.rng_state_out = seed_grid(w.rng_seed);
      default: ;
    endcase
    r.live_count = 13'(count_alive());
    return r;
  endfunction

  task automatic send_word(in_word_t w, bit typed, out_word_t typed_exp);
    out_word_t predicted;
    while (!calm && $urandom_range(99) < 35) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    item <= w;
    do @(posedge clk); while (full);
    predicted = apply_word(w);
    pending_results.push_back(typed ? typed_exp : predicted);
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(4 * idx);
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_COLS: cols_reg = v[6:0];
      REG_ROWS: rows_reg = v[6:0];
      REG_TRAIL: fade_len_reg = v[7:0];
      REG_ENABLE: fade_en_reg = v[0];
      REG_THRESH: density_reg = v;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  typedef struct {
    bit is_reg;
    int reg_idx;
    logic [31:0] reg_val;
    in_word_t w;
    bit typed;
    out_word_t exp;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void add_op(logic [2:0] op, int x, int y, bit al, logic [31:0] seed,
                                 bit typed = 0, out_word_t exp = '0);
    plan_row_t r;
    r = '{is_reg: 0, reg_idx: 0, reg_val: 0, w: '0, typed: typed, exp: exp};
    r.w = '{op: op, cell_x: 6'(x), cell_y: 6'(y), alive_in: al, rng_seed: seed};
    plan.push_back(r);
  endfunction

  function automatic void add_reg(int idx, logic [31:0] v);
    plan.push_back('{is_reg: 1, reg_idx: idx, reg_val: v, w: '0, typed: 0, exp: '0});
  endfunction

  function automatic out_word_t fixed_out(bit al, int tr, int lc, bit oor);
    out_word_t r;
    r = '0;
    r.cell_alive = al;
    r.cell_trail = 8'(tr);
    r.live_count = 13'(lc);
    r.out_of_range = oor;
    return r;
  endfunction

  task automatic report_field(string name, longint e, longint a);
    if (e != a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst && pop && !empty) begin
      pops_done++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %0h", $realtime, result);
      end else begin
        e = pending_results.pop_front();
        report_field("cell_alive", e.cell_alive, result.cell_alive);
        report_field("cell_trail", e.cell_trail, result.cell_trail);
        report_field("live_count", e.live_count, result.live_count);
        report_field("rng_state_out", e.rng_state_out, result.rng_state_out);
        report_field("out_of_range", e.out_of_range, result.out_of_range);
      end
    end
  end

  int hold_left = 0;
  bit hold_done = 0;
  always @(negedge clk) begin
    if (!hold_done && pops_done >= HOLD_AT_POP) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(99) >= 35);
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int cw, rh, pick, x, y;
    logic [2:0] op;
    for (int i = 0; i < NCELLS; i++) begin
      cell_live[i] = 1'b0;
      cell_fade[i] = 8'd0;
    end

    // Directed part: default 64 by 64 grid first, then small and degenerate grids.
    add_op(OP_READ, 0, 0, 0, 0, 1, fixed_out(0, 0, 0, 0));
    add_op(OP_READ, 63, 63, 1, 32'hffff_ffff, 1, fixed_out(0, 0, 0, 0));
    add_op(OP_SET, 63, 63, 1, 0, 1, fixed_out(0, 0, 1, 0));
    add_op(OP_READ, 63, 63, 0, 0, 1, fixed_out(1, 1, 1, 0));
    add_op(OP_SET, 63, 63, 0, 0, 1, fixed_out(0, 0, 0, 0));
    add_op(OP_READ, 63, 63, 0, 0, 1, fixed_out(0, 1, 0, 0));
    add_op(OP_BAD7, 63, 63, 1, 32'hffff_ffff, 1, fixed_out(0, 0, 0, 0));
    add_reg(REG_COLS, 3);
    add_reg(REG_ROWS, 3);
    add_reg(REG_TRAIL, 255);
    add_reg(REG_ENABLE, 1);
    add_op(OP_SET, 1, 0, 1, 0);
    add_op(OP_SET, 1, 1, 1, 0);
    add_op(OP_SET, 1, 2, 1, 0);
    add_op(OP_READ, 5, 1, 0, 0, 1, fixed_out(0, 0, 3, 1));
    add_op(OP_SET, 63, 0, 1, 0, 1, fixed_out(0, 0, 3, 1));
    add_op(OP_STEP, 0, 0, 0, 0);
    add_op(OP_READ, 0, 1, 0, 0);
    add_op(OP_STEP, 0, 0, 0, 0);
    add_reg(REG_COLS, 0);
    add_reg(REG_ROWS, 127);
    add_reg(REG_TRAIL, 0);
    add_op(OP_SET, 0, 5, 1, 0);
    add_op(OP_STEP, 0, 0, 0, 0);
    add_op(OP_READ, 0, 5, 0, 0);
    add_op(OP_CLEAR, 0, 0, 0, 0, 1, fixed_out(0, 0, 0, 0));
    add_reg(REG_COLS, 2);
    add_reg(REG_ROWS, 2);
    add_reg(REG_THRESH, 32'hffff_ffff);
    add_op(OP_SEED, 0, 0, 0, 32'h0);
    add_op(OP_SEED, 0, 0, 0, 32'hffff_ffff);
    add_reg(REG_THRESH, 0);
    add_reg(REG_ENABLE, 0);
    add_op(OP_SEED, 0, 0, 0, 32'h0001_2345);
    add_op(OP_READ, 1, 1, 0, 0);
    add_op(OP_BAD5, 0, 0, 0, 0);
    add_op(OP_BAD6, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].exp);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      calm = (p == 3);
      write_reg(REG_COLS, (p == 2) ? 64 : $urandom_range(1, 9));
      write_reg(REG_ROWS, (p == 5) ? 64 : $urandom_range(1, 9));
      write_reg(REG_TRAIL, (p == 1) ? 255 : $urandom_range(0, 255));
      write_reg(REG_ENABLE, $urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: write_reg(REG_THRESH, 0);
        1: write_reg(REG_THRESH, 32'hffff_ffff);
        default: write_reg(REG_THRESH, $urandom);
      endcase
      cw = active_cols();
      rh = active_rows();
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 32) op = OP_SET;
        else if (pick < 57) op = OP_READ;
        else if (pick < 80) op = OP_STEP;
        else if (pick < 90) op = OP_SEED;
        else if (pick < 94) op = OP_CLEAR;
        else op = 3'($urandom_range(5, 7));
        if ($urandom_range(99) < 75) begin
          x = $urandom_range(0, cw - 1);
          y = $urandom_range(0, rh - 1);
        end else begin
          x = $urandom_range(0, 63);
          y = $urandom_range(0, 63);
        end
        send_word('{op: op, cell_x: 6'(x), cell_y: 6'(y),
                    alive_in: 1'($urandom_range(0, 1)), rng_seed: $urandom}, 0, '0);
      end
    end

    calm = 1'b0;
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
src/tlg_pkg.sv
src/tlg_fifo.sv
src/tlg_front.sv
src/tlg_engine.sv
src/toroidal_life_grid_with_trails.sv
src/tlg_checker.sv
dv/testbench.sv
